// ===== hw/rtl/vdr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_pkg: shared types and constants of the dead-reckoning block
// Item and result words, CORDIC tables, fixed-point constants.
// ----------------------------------------------------------------------------
package vdr_pkg;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] control_value;
  } vdr_in_t;

  typedef struct packed {
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_z;
    logic [31:0]        heading;
    logic signed [31:0] speed;
  } vdr_out_t;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_STEER = 2'd1;
  localparam logic [1:0] KIND_PEDAL = 2'd2;

  localparam logic signed [33:0] FULL_TURN    = 34'sd3019898880;
  localparam logic signed [33:0] HALF_TURN    = 34'sd1509949440;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd754974720;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam int unsigned        CORDIC_ITERS = 24;

  // arctangent of 2^-i in degrees, Q23
  function automatic logic [28:0] atan_q23(input logic [4:0] i);
    logic [28:0] r;
    case (i)
      5'd0:  r = 29'd377487360;
      5'd1:  r = 29'd222843801;
      5'd2:  r = 29'd117744544;
      5'd3:  r = 29'd59768969;
      5'd4:  r = 29'd30000467;
      5'd5:  r = 29'd15014858;
      5'd6:  r = 29'd7509261;
      5'd7:  r = 29'd3754860;
      5'd8:  r = 29'd1877459;
      5'd9:  r = 29'd938733;
      5'd10: r = 29'd469367;
      5'd11: r = 29'd234683;
      5'd12: r = 29'd117342;
      5'd13: r = 29'd58671;
      5'd14: r = 29'd29335;
      5'd15: r = 29'd14668;
      5'd16: r = 29'd7334;
      5'd17: r = 29'd3667;
      5'd18: r = 29'd1833;
      5'd19: r = 29'd917;
      5'd20: r = 29'd458;
      5'd21: r = 29'd229;
      5'd22: r = 29'd115;
      5'd23: r = 29'd57;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vehicle_dead_reckoning_step_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vehicle_dead_reckoning_step_top: event-driven kinematic vehicle model
// Pedal, steer and tick events update speed, heading and Q24.16 position.
// From accept to valid, a tick runs a 24-step CORDIC then two multiplies, a
// steer a radix-2 divide, a pedal its quotient, split and accumulate steps; an
// unused kind goes straight to output. One word in flight, held through any
// output stall. Synchronous reset clears all state to zero, max_speed to 0.4.
// ----------------------------------------------------------------------------
module vehicle_dead_reckoning_step_top
  import vdr_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire vdr_pkg::vdr_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output vdr_pkg::vdr_out_t   out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [30:0]    cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_PEDAL_Q, S_PEDAL_SPLIT, S_PEDAL_ACC,
    S_STEER_ABS, S_STEER_SQ, S_STEER_DEN, S_STEER_DIV, S_STEER_WAIT,
    S_STEER_SCALE, S_STEER_TURN, S_TICK, S_TRIG, S_MUL_X, S_MUL_Z, S_OUT
  } state_t;

  state_t             state;
  logic [30:0]        max_speed;
  logic signed [31:0] cur_speed, cur_accel, turn_rate;
  logic [31:0]        cur_heading;
  logic signed [39:0] x_position, z_position;
  logic               item_neg;
  logic [15:0]        mag;
  logic [63:0]        div_a, div_b;
  logic               div_start, div_done;
  logic [63:0]        div_q;
  logic               cor_start, cor_done;
  logic signed [33:0] sn, cs;
  logic [31:0]        ms;
  logic [63:0]        mprod;
  logic signed [67:0] tprod;
  logic [7:0]         pq;
  logic [31:0]        pbase;
  logic [17:0]        prem;
  logic [47:0]        fprod;
  logic [31:0]        t5;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_OUT);
  assign out_data  = '{pos_x: x_position, pos_z: z_position,
                       heading: cur_heading, speed: cur_speed};

  vdr_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  vdr_cordic u_cor (
    .clk(clk), .rst(rst), .start(cor_start), .angle(cur_heading),
    .done(cor_done), .sin_q30(sn), .cos_q30(cs)
  );

  // speed update and heading wrap for a tick
  logic signed [33:0] sp, lim, hsum;
  always_comb begin
    lim = $signed({3'b0, max_speed});
    sp  = 34'(cur_speed) + 34'(cur_accel);
    if (sp >= lim) sp = lim;
    if (sp <= -lim) sp = -lim;
    hsum = $signed({2'b0, cur_heading}) + (34'(turn_rate) <<< 1);
    if (hsum < 0) hsum = hsum + FULL_TURN;
    else if (hsum >= FULL_TURN) hsum = hsum - FULL_TURN;
  end

  // constant divisions by reciprocal multiply
  // pedal: (q*2^30+500)/1000 = q*1073741 + (q*824+500)/1000
  // steer: y/1280 = (y/256)/5, /5 exact for any 32-bit value
  logic [36:0] pscaled;
  logic [31:0] pacc;
  logic [65:0] tscaled;
  logic [31:0] tq;
  always_comb begin
    pscaled = 37'(prem) * 37'd268436;
    pacc    = pbase + 32'(pscaled >> 28);
    tscaled = 66'(t5) * 66'd3435973837;
    tq      = 32'(tscaled >> 34);
  end

  logic signed [39:0] delta;
  assign delta = 40'((tprod + (68'sd1 <<< 43)) >>> 44);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_speed   <= 31'd429496730;
      cur_speed   <= '0;
      cur_accel   <= '0;
      turn_rate   <= '0;
      cur_heading <= '0;
      x_position  <= '0;
      z_position  <= '0;
      div_start   <= 1'b0;
      cor_start   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      cor_start <= 1'b0;
      if (cfg_valid) max_speed <= cfg_data;
      case (state)
        S_IDLE: if (in_valid) begin
          item_neg <= in_data.control_value[15];
          mag <= in_data.control_value[15] ? 16'(-in_data.control_value)
                                           : in_data.control_value;
          case (in_data.kind)
            KIND_PEDAL: state <= S_PEDAL_Q;
            KIND_STEER: state <= S_STEER_ABS;
            KIND_TICK:  state <= S_TICK;
            default:    state <= S_OUT;
          endcase
        end
        // q = floor(|v|/200), exact for |v| up to 32768
        S_PEDAL_Q: begin
          pq    <= 8'((29'(mag) * 29'd5243) >> 20);
          state <= S_PEDAL_SPLIT;
        end
        S_PEDAL_SPLIT: begin
          pbase <= 32'(pq) * 32'd1073741;
          prem  <= 18'(pq) * 18'd824 + 18'd500;
          state <= S_PEDAL_ACC;
        end
        S_PEDAL_ACC: begin
          cur_accel <= item_neg ? -$signed(pacc) : $signed(pacc);
          state     <= S_OUT;
        end
        S_STEER_ABS: begin
          ms    <= cur_speed[31] ? 32'(-cur_speed) : cur_speed;
          state <= S_STEER_SQ;
        end
        S_STEER_SQ: begin
          mprod <= 64'(ms) * 64'(ms);
          state <= S_STEER_DEN;
        end
        // d = 2^30 + 500*floor(s^2/2^30)
        S_STEER_DEN: begin
          div_b <= 64'd1073741824 + 64'd500 * (mprod >> 30);
          state <= S_STEER_DIV;
        end
        // f = (|s|*2^30 + d/2)/d
        S_STEER_DIV: begin
          div_a     <= (64'(ms) << 30) + (div_b >> 1);
          div_start <= 1'b1;
          state     <= S_STEER_WAIT;
        end
        S_STEER_WAIT: if (div_done) begin
          fprod <= 48'(div_q[31:0]) * 48'(mag);
          state <= S_STEER_SCALE;
        end
        S_STEER_SCALE: begin
          t5    <= 32'((fprod + 48'd640) >> 8);
          state <= S_STEER_TURN;
        end
        S_STEER_TURN: begin
          turn_rate <= (cur_speed[31] != item_neg) ? -$signed(tq) : $signed(tq);
          state     <= S_OUT;
        end
        S_TICK: begin
          cur_speed   <= 32'(sp);
          cur_heading <= 32'(hsum);
          cor_start   <= 1'b1;
          state       <= S_TRIG;
        end
        S_TRIG: if (cor_done) begin
          tprod <= 68'(sn) * 68'(cur_speed);
          state <= S_MUL_X;
        end
        S_MUL_X: begin
          x_position <= x_position - delta;
          tprod      <= 68'(cs) * 68'(cur_speed);
          state      <= S_MUL_Z;
        end
        S_MUL_Z: begin
          z_position <= z_position - delta;
          state      <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/vdr_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_divider: restoring radix-2 unsigned divider
// One quotient bit per cycle; quotient and remainder held when done.
// ----------------------------------------------------------------------------
module vdr_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dsr;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  // shift in next dividend bit and try subtract
  assign trial = {rem, quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

// ===== hw/rtl/vdr_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vdr_cordic: iterative degree-domain CORDIC
// Folds heading to [-90,90], then 24 rotation steps; Q30 sine and cosine.
// ----------------------------------------------------------------------------
module vdr_cordic
  import vdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] angle,
  output logic             done,
  output logic signed [33:0] sin_q30,
  output logic signed [33:0] cos_q30
);

  logic signed [33:0] a, x, y;
  logic               neg;
  logic [4:0]         step;
  logic               busy;
  logic signed [33:0] a0, a1;
  logic               neg0;
  logic signed [33:0] ys, xs, at;

  // fold the angle into [-90, 90]
  always_comb begin
    a0   = $signed({2'b00, angle});
    if (a0 > HALF_TURN) a0 = a0 - FULL_TURN;
    a1   = a0;
    neg0 = 1'b0;
    if (a0 > QUARTER_TURN) begin
      a1 = a0 - HALF_TURN;
      neg0 = 1'b1;
    end else if (a0 < -QUARTER_TURN) begin
      a1 = a0 + HALF_TURN;
      neg0 = 1'b1;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign ys = y >>> step;
  assign xs = x >>> step;
  assign at = $signed({5'b0, atan_q23(step)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        a    <= a1;
        neg  <= neg0;
        x    <= CORDIC_START;
        y    <= '0;
        step <= '0;
      end else if (busy) begin
        if (!a[33]) begin
          x <= x - ys;
          y <= y + xs;
          a <= a - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          a <= a + at;
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sin_q30 = neg ? -y : y;
  assign cos_q30 = neg ? -x : x;

endmodule
`default_nettype wire
